>>> hw/rtl/leaky_lms_adaptive_fir_unit_defines.svh
// ----------------------------------------------------------------------------
// Leaky LMS adaptive FIR unit - assertion macros
// Shared property forms for the concurrent checks of the unit.
// ----------------------------------------------------------------------------
`ifndef LEAKY_LMS_ADAPTIVE_FIR_UNIT_DEFINES_SVH
`define LEAKY_LMS_ADAPTIVE_FIR_UNIT_DEFINES_SVH

// same-cycle implication
`define LLMS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LLMS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/llms_pkg.sv
// ----------------------------------------------------------------------------
// Leaky LMS adaptive FIR unit - package
// Widths, reset values, register indexes and control word types.
// ----------------------------------------------------------------------------
package llms_pkg;

   localparam int TAPS_DEF   = 10;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 24;
   localparam int CFG_W      = 16;
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;
   localparam int EST_SHIFT  = 20;
   localparam int LEAK_SHIFT = 16;
   localparam int UPD_SHIFT  = 26;
   localparam int UPD_LAT    = 3;

   localparam logic [CFG_W-1:0] STEP_RESET = 16'd6554;
   localparam logic [CFG_W-1:0] LEAK_RESET = 16'd64881;

   localparam logic [ADDR_W-3:0] REG_STEP_SIZE   = 1'b0;
   localparam logic [ADDR_W-3:0] REG_LEAK_FACTOR = 1'b1;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;
   localparam logic signed [COEF_W-1:0]   COEF_MAX   = 24'sh7FFFFF;
   localparam logic signed [COEF_W-1:0]   COEF_MIN   = -24'sh800000;

   typedef struct packed {
      logic tap_en;
      logic coef_en;
   } cell_ctl_type;

   typedef struct packed {
      logic clr;
      logic en;
   } mac_ctl_type;

   // accumulator width for a given tap count
   function automatic int acc_w(input int taps);
      return COEF_W + SAMPLE_W + $clog2(taps);
   endfunction

   // width of estimate error
   function automatic int err_w(input int taps);
      return acc_w(taps) - EST_SHIFT + 1;
   endfunction

endpackage

>>> hw/rtl/llms_cell.sv
// ----------------------------------------------------------------------------
// Leaky LMS adaptive FIR unit - ring cell
// Holds one tap sample and one coefficient; loads both from its neighbour.
// ----------------------------------------------------------------------------
module llms_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  llms_pkg::cell_ctl_type               ctl,
   input  logic signed [llms_pkg::SAMPLE_W-1:0] tap_in,
   input  logic signed [llms_pkg::COEF_W-1:0]   coef_in,
   output logic signed [llms_pkg::SAMPLE_W-1:0] tap_out,
   output logic signed [llms_pkg::COEF_W-1:0]   coef_out
);
   import llms_pkg::*;

   logic signed [SAMPLE_W-1:0] tap_ff;
   logic signed [COEF_W-1:0]   coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff  <= '0;
         coef_ff <= '0;
      end else begin
         if (ctl.tap_en) begin
            tap_ff <= tap_in;
         end
         if (ctl.coef_en) begin
            coef_ff <= coef_in;
         end
      end
   end

   assign tap_out  = tap_ff;
   assign coef_out = coef_ff;

endmodule

>>> hw/rtl/llms_mac.sv
// ----------------------------------------------------------------------------
// Leaky LMS adaptive FIR unit - estimate MAC
// Accumulates coefficient-tap products off the ring head; forms the error.
// ----------------------------------------------------------------------------
module llms_mac #(
   parameter int TAPS = llms_pkg::TAPS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  llms_pkg::mac_ctl_type                      ctl,
   input  logic signed [llms_pkg::SAMPLE_W-1:0]       tap,
   input  logic signed [llms_pkg::COEF_W-1:0]         coef,
   input  logic signed [llms_pkg::SAMPLE_W-1:0]       desired,
   output logic signed [llms_pkg::err_w(TAPS)-1:0]    err
);
   import llms_pkg::*;

   localparam int PROD_W = COEF_W + SAMPLE_W;
   localparam int ACC_W  = acc_w(TAPS);
   localparam int ERR_W  = err_w(TAPS);
   localparam logic signed [ACC_W-1:0] EST_RND = ACC_W'(1) <<< (EST_SHIFT - 1);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ERR_W-1:0]  est;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         vld_ff <= ctl.en;
         if (ctl.clr) begin
            acc_ff <= '0;
         end else if (vld_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
      prod_ff <= coef * tap;
   end

   assign est = ERR_W'((acc_ff + EST_RND) >>> EST_SHIFT);
   assign err = ERR_W'(desired) - est;

endmodule

>>> hw/rtl/llms_upd.sv
// ----------------------------------------------------------------------------
// Leaky LMS adaptive FIR unit - coefficient update pipeline
// Three stages: leak*w + mu*err*tap, rounded and saturated; tap rides along.
// ----------------------------------------------------------------------------
module llms_upd #(
   parameter int TAPS = llms_pkg::TAPS_DEF
) (
   input  logic                                    clock,
   input  logic                                    load,
   input  logic signed [llms_pkg::err_w(TAPS)-1:0] err,
   input  logic [llms_pkg::CFG_W-1:0]              mu,
   input  logic [llms_pkg::CFG_W-1:0]              leak,
   input  logic signed [llms_pkg::SAMPLE_W-1:0]    tap_in,
   input  logic signed [llms_pkg::COEF_W-1:0]      coef_in,
   output logic signed [llms_pkg::SAMPLE_W-1:0]    tap_out,
   output logic signed [llms_pkg::COEF_W-1:0]      coef_out
);
   import llms_pkg::*;

   localparam int ERR_W   = err_w(TAPS);
   localparam int MU_W    = CFG_W + 1;
   localparam int EMU_W   = ERR_W + MU_W;
   localparam int LO_W    = EMU_W / 2;
   localparam int HI_W    = EMU_W - LO_W;
   localparam int PLO_W   = LO_W + 1 + SAMPLE_W;
   localparam int PHI_W   = HI_W + SAMPLE_W;
   localparam int UPD_W   = EMU_W + SAMPLE_W + 1;
   localparam int LEAKP_W = MU_W + COEF_W;
   localparam int LEAKR_W = LEAKP_W - LEAK_SHIFT;
   localparam int SUM_W   = UPD_W - UPD_SHIFT + 1;
   localparam logic signed [UPD_W-1:0]   UPD_RND  = UPD_W'(1) <<< (UPD_SHIFT - 1);
   localparam logic signed [LEAKP_W-1:0] LEAK_RND = LEAKP_W'(1) <<< (LEAK_SHIFT - 1);

   logic signed [MU_W-1:0]     mu_s;
   logic signed [MU_W-1:0]     leak_s;
   logic signed [EMU_W-1:0]    emu_ff;
   logic signed [LO_W:0]       emu_lo;
   logic signed [HI_W-1:0]     emu_hi;
   logic signed [PLO_W-1:0]    plo_ff;
   logic signed [PHI_W-1:0]    phi_ff;
   logic signed [LEAKP_W-1:0]  leakp_ff;
   logic signed [SAMPLE_W-1:0] tap1_ff;
   logic signed [UPD_W-1:0]    upd_ff;
   logic signed [LEAKR_W-1:0]  leakr_ff;
   logic signed [SAMPLE_W-1:0] tap2_ff;
   logic signed [SUM_W-1:0]    sum;
   logic signed [COEF_W-1:0]   coef_sat;
   logic signed [SAMPLE_W-1:0] tap3_ff;
   logic signed [COEF_W-1:0]   coef3_ff;

   assign mu_s   = signed'({1'b0, mu});
   assign leak_s = signed'({1'b0, leak});
   assign emu_lo = signed'({1'b0, emu_ff[LO_W-1:0]});
   assign emu_hi = signed'(emu_ff[EMU_W-1:LO_W]);

   assign sum = SUM_W'(upd_ff >>> UPD_SHIFT) + SUM_W'(leakr_ff);

   always_comb begin
      if (&sum[SUM_W-1:COEF_W-1] || ~|sum[SUM_W-1:COEF_W-1]) begin
         coef_sat = sum[COEF_W-1:0];
      end else if (sum[SUM_W-1]) begin
         coef_sat = COEF_MIN;
      end else begin
         coef_sat = COEF_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         emu_ff <= err * mu_s;
      end
      // stage 1: partial products
      plo_ff   <= emu_lo * tap_in;
      phi_ff   <= emu_hi * tap_in;
      leakp_ff <= leak_s * coef_in;
      tap1_ff  <= tap_in;
      // stage 2: join partials, round leak term
      upd_ff   <= (UPD_W'(phi_ff) <<< LO_W) + UPD_W'(plo_ff) + UPD_RND;
      leakr_ff <= LEAKR_W'((leakp_ff + LEAK_RND) >>> LEAK_SHIFT);
      tap2_ff  <= tap1_ff;
      // stage 3: sum and saturate
      coef3_ff <= coef_sat;
      tap3_ff  <= tap2_ff;
   end

   assign tap_out  = tap3_ff;
   assign coef_out = coef3_ff;

endmodule

>>> hw/rtl/leaky_lms_adaptive_fir_unit.sv
// ----------------------------------------------------------------------------
// Leaky LMS adaptive FIR unit - top level
// Each request word carries a reference sample and a desired sample; the
// response word is the a posteriori error, saturated to Q1.15. Taps and
// coefficients sit in a ring of TAPS cells that rotates past one shared
// multiply-accumulate (estimate) and a three-stage update pipeline. Each word
// runs two estimate passes and one update pass round the ring, plus
// sequencing, before the next can be taken. Step size lives at byte address 0
// and the leak factor at 4, both unsigned Q0.16; write them only while idle.
// ----------------------------------------------------------------------------
`include "leaky_lms_adaptive_fir_unit_defines.svh"

module leaky_lms_adaptive_fir_unit #(
   parameter int TAPS = llms_pkg::TAPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [llms_pkg::SAMPLE_W-1:0] req_filter_input,
   input  logic signed [llms_pkg::SAMPLE_W-1:0] req_desired_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [llms_pkg::SAMPLE_W-1:0] rsp_error_out,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [llms_pkg::ADDR_W-1:0]          paddr,
   input  logic [llms_pkg::DATA_W-1:0]          pwdata,
   output logic [llms_pkg::DATA_W-1:0]          prdata,
   output logic                                 pready
);
   import llms_pkg::*;

   localparam int ERR_W = err_w(TAPS);
   localparam int CNT_W = $clog2(TAPS + UPD_LAT);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EST, ST_DRAIN, ST_ERR, ST_MU, ST_UPD, ST_POST
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       pass_ff, pass_in;
   logic signed [SAMPLE_W-1:0] desired_ff, desired_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [CFG_W-1:0]           step_ff;
   logic [CFG_W-1:0]           leak_ff;

   logic                       req_accept;
   logic                       csr_write;
   logic [ADDR_W-3:0]          csr_idx;
   cell_ctl_type               cell_ctl;
   mac_ctl_type                mac_ctl;
   logic signed [SAMPLE_W-1:0] ring_tap;
   logic signed [COEF_W-1:0]   ring_coef;
   logic signed [SAMPLE_W-1:0] tap_q  [TAPS];
   logic signed [COEF_W-1:0]   coef_q [TAPS];
   logic signed [SAMPLE_W-1:0] upd_tap;
   logic signed [COEF_W-1:0]   upd_coef;
   logic signed [ERR_W-1:0]    mac_err;
   logic signed [SAMPLE_W-1:0] post_sat;

   // config registers
   assign pready    = 1'b1;
   assign csr_idx   = paddr[ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         leak_ff <= LEAK_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            REG_STEP_SIZE:   step_ff <= pwdata[CFG_W-1:0];
            REG_LEAK_FACTOR: leak_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_STEP_SIZE:   prdata = DATA_W'(step_ff);
         REG_LEAK_FACTOR: prdata = DATA_W'(leak_ff);
         default:         prdata = '0;
      endcase
   end

   // ring of cells
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      ring_tap  = tap_q[TAPS-1];
      ring_coef = coef_q[TAPS-1];
      cell_ctl  = '0;
      case (state_ff)
         ST_IDLE: begin
            ring_tap        = req_filter_input;
            cell_ctl.tap_en = req_accept;
         end
         ST_EST: begin
            cell_ctl.tap_en  = 1'b1;
            cell_ctl.coef_en = 1'b1;
         end
         ST_UPD: begin
            ring_tap         = upd_tap;
            ring_coef        = upd_coef;
            cell_ctl.tap_en  = 1'b1;
            cell_ctl.coef_en = 1'b1;
         end
         default: ;
      endcase
   end

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      if (i == 0) begin : g_head
         llms_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (cell_ctl),
            .tap_in   (ring_tap),
            .coef_in  (ring_coef),
            .tap_out  (tap_q[i]),
            .coef_out (coef_q[i])
         );
      end else begin : g_body
         llms_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (cell_ctl),
            .tap_in   (tap_q[i-1]),
            .coef_in  (coef_q[i-1]),
            .tap_out  (tap_q[i]),
            .coef_out (coef_q[i])
         );
      end
   end

   assign mac_ctl.clr = req_accept || (state_ff == ST_MU);
   assign mac_ctl.en  = (state_ff == ST_EST);

   llms_mac #(.TAPS(TAPS)) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .tap     (tap_q[TAPS-1]),
      .coef    (coef_q[TAPS-1]),
      .desired (desired_ff),
      .err     (mac_err)
   );

   llms_upd #(.TAPS(TAPS)) u_upd (
      .clock    (clock),
      .load     (state_ff == ST_MU),
      .err      (err_ff),
      .mu       (step_ff),
      .leak     (leak_ff),
      .tap_in   (tap_q[TAPS-1]),
      .coef_in  (coef_q[TAPS-1]),
      .tap_out  (upd_tap),
      .coef_out (upd_coef)
   );

   always_comb begin
      if (&mac_err[ERR_W-1:SAMPLE_W-1] || ~|mac_err[ERR_W-1:SAMPLE_W-1]) begin
         post_sat = mac_err[SAMPLE_W-1:0];
      end else if (mac_err[ERR_W-1]) begin
         post_sat = SAMPLE_MIN;
      end else begin
         post_sat = SAMPLE_MAX;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      desired_in   = desired_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in   = ST_EST;
               cnt_in     = '0;
               pass_in    = 1'b0;
               desired_in = req_desired_sample;
            end
         end
         ST_EST: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TAPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = pass_ff ? ST_POST : ST_ERR;
         end
         ST_ERR: begin
            err_in   = mac_err;
            state_in = ST_MU;
         end
         ST_MU: begin
            cnt_in   = '0;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TAPS + UPD_LAT - 1)) begin
               cnt_in   = '0;
               pass_in  = 1'b1;
               state_in = ST_EST;
            end
         end
         ST_POST: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = post_sat;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      desired_ff  <= desired_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_error_out = rsp_data_ff;

   `LLMS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_accept, req_stall && (state_ff == ST_EST), "word accepted but estimate pass not started")
   `LLMS_ASSERT_IMP(a_rsp_from_post, clock, reset, $rose(rsp_valid), $past(state_ff == ST_POST), "response raised outside final step")
   `LLMS_ASSERT_IMP(a_est_cnt_range, clock, reset, state_ff == ST_EST, cnt_ff < CNT_W'(TAPS), "estimate pass ran past the ring length")

endmodule

>>> bench/leaky_lms_adaptive_fir_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Leaky LMS adaptive FIR unit - testbench
// Drives sample words through the request channel and compares every error
// word against an in-bench fixed-point model of the tap line, the leaky LMS
// coefficient update and the a posteriori error. Covers register access,
// field extremes, coefficient and output saturation, zero gain, then random
// phases over several step and leak settings with random idling and stalls.
// ----------------------------------------------------------------------------
module leaky_lms_adaptive_fir_unit_tb;

   import llms_pkg::*;

   localparam int TAPS   = TAPS_DEF;
   localparam int SETTLE = 3 * TAPS + 12;
   localparam int LIMIT  = 400000;

   localparam logic [ADDR_W-1:0] STEP_ADDR = {REG_STEP_SIZE, 2'b00};
   localparam logic [ADDR_W-1:0] LEAK_ADDR = {REG_LEAK_FACTOR, 2'b00};

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   sample_type          req_filter_input = '0;
   sample_type          req_desired_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   sample_type          rsp_error_out;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // model state
   sample_type          tap_hist [TAPS];
   coef_type            weight [TAPS];
   logic [CFG_W-1:0]    mu_q16 = STEP_RESET;
   logic [CFG_W-1:0]    lambda_q16 = LEAK_RESET;

   sample_type          expected_errors [$];
   sample_type          prev_x = '0;
   int                  n_mismatch = 0;
   int                  cycle_count = 0;
   int                  stall_left = 0;
   bit                  quiet = 1'b0;

   leaky_lms_adaptive_fir_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_filter_input   (req_filter_input),
      .req_desired_sample (req_desired_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_error_out      (rsp_error_out),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // fixed-point model
   // ------------------------------------------------------------------
   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint fir_estimate();
      longint acc;
      acc = 0;
      for (int i = 0; i < TAPS; i++)
         acc += longint'(weight[i]) * longint'(tap_hist[i]);
      return round_shift(acc, EST_SHIFT);
   endfunction

   function automatic sample_type adapt_and_filter(input sample_type x, input sample_type d);
      longint err;
      longint nw;
      longint post;
      for (int i = TAPS - 1; i > 0; i--)
         tap_hist[i] = tap_hist[i-1];
      tap_hist[0] = x;
      err = longint'(d) - fir_estimate();
      for (int i = 0; i < TAPS; i++) begin
         nw = round_shift(longint'(lambda_q16) * longint'(weight[i]), LEAK_SHIFT)
            + round_shift(err * longint'(mu_q16) * longint'(tap_hist[i]), UPD_SHIFT);
         if (nw > longint'(COEF_MAX)) nw = longint'(COEF_MAX);
         if (nw < longint'(COEF_MIN)) nw = longint'(COEF_MIN);
         weight[i] = coef_type'(nw);
      end
      post = longint'(d) - fir_estimate();
      if (post > longint'(SAMPLE_MAX)) post = longint'(SAMPLE_MAX);
      if (post < longint'(SAMPLE_MIN)) post = longint'(SAMPLE_MIN);
      return sample_type'(post);
   endfunction

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input longint exp_v, input longint act_v);
      n_mismatch++;
      if (n_mismatch <= 10)
         $display("mismatch %s: expected %0d, got %0d (cycle %0d)",
                  what, exp_v, act_v, cycle_count);
   endtask

   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      sample_type exp_e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_errors.size() == 0) begin
            report_mismatch("unexpected word, error_out", 0, rsp_error_out);
         end else begin
            exp_e = expected_errors.pop_front();
            if (rsp_error_out !== exp_e)
               report_mismatch("error_out", exp_e, rsp_error_out);
         end
      end
   end

   // ------------------------------------------------------------------
   // request side and register port
   // ------------------------------------------------------------------
   task automatic send_word(input sample_type x, input sample_type d);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_filter_input   <= x;
      req_desired_sample <= d;
      do @(posedge clock); while (req_stall);
      expected_errors.push_back(adapt_and_filter(x, d));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_errors.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == STEP_ADDR) mu_q16 = data[CFG_W-1:0];
      else if (addr == LEAK_ADDR) lambda_q16 = data[CFG_W-1:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] exp_v);
      logic [DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      if (got !== DATA_W'(exp_v))
         report_mismatch($sformatf("register read at %0d", addr), exp_v, got);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_gains(input logic [DATA_W-1:0] step, input logic [DATA_W-1:0] leak);
      wait_idle();
      csr_write(STEP_ADDR, step);
      csr_write(LEAK_ADDR, leak);
      check_reg(STEP_ADDR, step[CFG_W-1:0]);
      check_reg(LEAK_ADDR, leak[CFG_W-1:0]);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic check_registers();
      check_reg(STEP_ADDR, STEP_RESET);
      check_reg(LEAK_ADDR, LEAK_RESET);
      // bits above the register width are dropped
      csr_write(STEP_ADDR, 32'hA5C3_0000 | 32'h0000_5AA5);
      csr_write(LEAK_ADDR, 32'hFFFF_0000 | 32'h0000_A55A);
      check_reg(STEP_ADDR, 16'h5AA5);
      check_reg(LEAK_ADDR, 16'hA55A);
      csr_write(STEP_ADDR, {16'hFFFF, STEP_RESET});
      csr_write(LEAK_ADDR, {16'h8000, LEAK_RESET});
      check_reg(STEP_ADDR, STEP_RESET);
      check_reg(LEAK_ADDR, LEAK_RESET);
   endtask

   task automatic run_field_extremes();
      send_word(16'sd0, 16'sd0);
      send_word(SAMPLE_MAX, SAMPLE_MAX);
      send_word(SAMPLE_MIN, SAMPLE_MIN);
      send_word(SAMPLE_MAX, SAMPLE_MIN);
      send_word(SAMPLE_MIN, SAMPLE_MAX);
      send_word(-16'sd1, 16'sd1);
      send_word(16'sh5555, -16'sh5556);
      send_word(-16'sh5556, 16'sh5555);
   endtask

   // full step and no leak diverge, so coefficients and the output both clip
   task automatic run_saturation();
      set_gains(32'h0000_FFFF, 32'h0000_FFFF);
      repeat (3) begin
         send_word(SAMPLE_MAX, SAMPLE_MIN);
         send_word(SAMPLE_MIN, SAMPLE_MAX);
         send_word(SAMPLE_MAX, SAMPLE_MAX);
         send_word(SAMPLE_MIN, SAMPLE_MIN);
      end
   endtask

   task automatic run_zero_gain();
      set_gains(32'h0, 32'h0);
      send_word(SAMPLE_MAX, 16'sd1234);
      send_word(SAMPLE_MIN, -16'sd1234);
      send_word(16'sd300, SAMPLE_MAX);
      send_word(-16'sd300, SAMPLE_MIN);
   endtask

   task automatic run_random_phases();
      sample_type corner_vals [4] = '{SAMPLE_MAX, SAMPLE_MIN, 16'sd0, -16'sd1};
      sample_type x;
      sample_type d;
      int dv;
      int kind;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_gains(DATA_W'(STEP_RESET), DATA_W'(LEAK_RESET));
            1: set_gains($urandom_range(0, 65535), 32'h0000_FFFF);
            2: set_gains(32'h0000_FFFF, $urandom_range(0, 65535));
            3: set_gains($urandom_range(1, 2000), $urandom_range(60000, 65535));
            4: set_gains($urandom, $urandom);
            default: begin
               set_gains(DATA_W'(STEP_RESET), 32'h0000_FFFF);
               quiet = 1'b1;
            end
         endcase
         for (int n = 0; n < 140; n++) begin
            kind = $urandom_range(0, 9);
            x = sample_type'($urandom);
            d = sample_type'($urandom);
            if (kind < 6) begin
               // plant to be identified: two-tap system plus a little noise
               x  = x >>> $urandom_range(0, 3);
               dv = (3 * int'(x)) / 4 - int'(prev_x) / 2 + int'($urandom_range(0, 512)) - 256;
               if (dv > int'(SAMPLE_MAX)) dv = int'(SAMPLE_MAX);
               if (dv < int'(SAMPLE_MIN)) dv = int'(SAMPLE_MIN);
               d = sample_type'(dv);
            end else if (kind == 8) begin
               x = corner_vals[$urandom_range(0, 3)];
               d = corner_vals[$urandom_range(0, 3)];
            end else if (kind == 9) begin
               x = x >>> 8;
               d = d >>> 8;
            end
            prev_x = x;
            send_word(x, d);
            if (n % 50 == 49) begin
               req_valid <= 1'b0;
               while (expected_errors.size() != 0) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i < TAPS; i++) begin
         tap_hist[i] = '0;
         weight[i]   = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_registers();
      run_field_extremes();
      run_saturation();
      run_zero_gain();
      run_random_phases();
      wait_idle();
      if (n_mismatch == 0 && expected_errors.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
